>>> hdl/midi_event_stream_parser_macros.svh
// assertion macros used by the parser top module
`ifndef MIDI_EVENT_STREAM_PARSER_MACROS_SVH
`define MIDI_EVENT_STREAM_PARSER_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define MESP_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define MESP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/mesp_pkg.sv
package mesp_pkg;

	typedef enum logic [2:0] {
		KIND_NOTE_OFF  = 3'd0,
		KIND_NOTE_ON   = 3'd1,
		KIND_KEY_PRESS = 3'd2,
		KIND_CTRL      = 3'd3,
		KIND_PROGRAM   = 3'd4,
		KIND_CHAN_PRESS = 3'd5,
		KIND_BEND      = 3'd6,
		KIND_DELAY     = 3'd7
	} kind_t;

	typedef enum logic [4:0] {
		PH_DELAY_FIRST  = 5'b00001,
		PH_DELAY_SECOND = 5'b00010,
		PH_EVENT_START  = 5'b00100,
		PH_DATA_ONE     = 5'b01000,
		PH_DATA_TWO     = 5'b10000
	} phase_t;

	localparam logic [7:0] STATUS_FLAG   = 8'h80;
	localparam logic [2:0] ONE_DATA_TOP  = 3'b110;
	localparam logic [2:0] SYSTEM_GROUP  = 3'b111;

	// classified transaction handed from front to back
	// for a delay, first_data:second_data holds the 14-bit tick count
	typedef struct packed {
		kind_t      kind;
		logic [3:0] channel;
		logic [6:0] first_data;
		logic [6:0] second_data;
	} entry_t;

endpackage

>>> hdl/mesp_front.sv
module mesp_front import mesp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       q_full,
	input  logic [7:0] stream_byte,
	output logic       push,
	output entry_t     push_entry
);

	phase_t     phase_q, phase_n;
	logic [7:0] status_q, status_n;
	logic [6:0] held_q, held_n;
	logic [6:0] delay_hi_q, delay_hi_n;

	logic       accept;
	logic       do_first;
	logic       do_finish;
	logic [6:0] first_d;
	logic [6:0] fin_d1;
	logic [6:0] fin_d2;

	assign accept = in_valid && !q_full;

	always_comb begin
		phase_n    = phase_q;
		status_n   = status_q;
		held_n     = held_q;
		delay_hi_n = delay_hi_q;
		push       = 1'b0;
		push_entry = '{kind: KIND_DELAY, channel: 4'd0, first_data: 7'd0,
			second_data: 7'd0};
		do_first   = 1'b0;
		do_finish  = 1'b0;
		first_d    = stream_byte[6:0];
		fin_d1     = held_q;
		fin_d2     = stream_byte[6:0];
		if (accept) begin
			unique case (phase_q)
				PH_DELAY_FIRST: begin
					if (stream_byte[7]) begin
						delay_hi_n = stream_byte[6:0];
						phase_n    = PH_DELAY_SECOND;
					end else begin
						push                   = 1'b1;
						push_entry.second_data = stream_byte[6:0];
						phase_n                = PH_EVENT_START;
					end
				end
				PH_DELAY_SECOND: begin
					// bit 7 of the second byte overlaps the low bit of the high part
					push                   = 1'b1;
					push_entry.first_data  = delay_hi_q | {6'd0, stream_byte[7]};
					push_entry.second_data = stream_byte[6:0];
					phase_n                = PH_EVENT_START;
				end
				PH_EVENT_START: begin
					if (stream_byte[7]) begin
						status_n = stream_byte;
						phase_n  = PH_DATA_ONE;
					end else begin
						do_first = 1'b1;
					end
				end
				PH_DATA_ONE: begin
					do_first = 1'b1;
				end
				PH_DATA_TWO: begin
					do_finish = 1'b1;
				end
				default: begin
					phase_n = PH_DELAY_FIRST;
				end
			endcase
		end

		if (do_first) begin
			if (status_q[7:5] == ONE_DATA_TOP) begin
				do_finish = 1'b1;
				fin_d1    = first_d;
				fin_d2    = 7'd0;
			end else begin
				held_n  = first_d;
				phase_n = PH_DATA_TWO;
			end
		end

		if (do_finish) begin
			phase_n = PH_DELAY_FIRST;
			// system statuses and the no-status case emit nothing
			if ((status_q & STATUS_FLAG) != 8'd0 && status_q[6:4] != SYSTEM_GROUP) begin
				push                   = 1'b1;
				push_entry.kind        = kind_t'(status_q[6:4]);
				push_entry.channel     = status_q[3:0];
				push_entry.first_data  = fin_d1;
				push_entry.second_data = fin_d2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_DELAY_FIRST;
			status_q   <= 8'd0;
			held_q     <= 7'd0;
			delay_hi_q <= 7'd0;
		end else begin
			phase_q    <= phase_n;
			status_q   <= status_n;
			held_q     <= held_n;
			delay_hi_q <= delay_hi_n;
		end
	end

endmodule

>>> hdl/mesp_queue.sv
module mesp_queue import mesp_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output logic   q_valid,
	output logic   q_full,
	output entry_t q_entry
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign q_valid = count_q != '0;
	assign q_full  = count_q == CW'(DEPTH);
	assign q_entry = mem_q[rd_ptr_q];
	assign do_push = push && !q_full;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/mesp_back.sv
module mesp_back import mesp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  entry_t      q_entry,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_kind,
	output logic [3:0]  channel,
	output logic [6:0]  first_data,
	output logic [6:0]  second_data,
	output logic [13:0] wide_value
);

	logic        valid_q;
	kind_t       kind_q, kind_n;
	logic [3:0]  chn_q, chn_n;
	logic [6:0]  d1_q, d1_n;
	logic [6:0]  d2_q, d2_n;
	logic [13:0] wide_q, wide_n;

	assign pop = q_valid && (!valid_q || !out_stall);

	always_comb begin
		kind_n = q_entry.kind;
		chn_n  = q_entry.channel;
		d1_n   = q_entry.first_data;
		d2_n   = q_entry.second_data;
		wide_n = 14'd0;
		unique case (q_entry.kind)
			KIND_NOTE_ON: begin
				// zero velocity means note off
				if (q_entry.second_data == 7'd0) begin
					kind_n = KIND_NOTE_OFF;
				end
			end
			KIND_NOTE_OFF, KIND_KEY_PRESS, KIND_CTRL: begin
			end
			KIND_PROGRAM: begin
				d2_n = 7'd0;
			end
			KIND_CHAN_PRESS: begin
				d1_n = 7'd0;
				d2_n = q_entry.first_data;
			end
			KIND_BEND: begin
				d1_n   = 7'd0;
				d2_n   = 7'd0;
				wide_n = {q_entry.second_data, q_entry.first_data};
			end
			KIND_DELAY: begin
				chn_n  = 4'd0;
				d1_n   = 7'd0;
				d2_n   = 7'd0;
				wide_n = {q_entry.first_data, q_entry.second_data};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= kind_n;
			chn_q  <= chn_n;
			d1_q   <= d1_n;
			d2_q   <= d2_n;
			wide_q <= wide_n;
		end
	end

	assign out_valid   = valid_q;
	assign event_kind  = kind_q;
	assign channel     = chn_q;
	assign first_data  = d1_q;
	assign second_data = d2_q;
	assign wide_value  = wide_q;

endmodule

>>> hdl/midi_event_stream_parser.sv
// one stream byte accepted per cycle, sustained, while the queue has room
// a byte that completes a delay or channel event is written into the queue at its
// accepting edge and loaded into the output register once that is empty or not stalled
// the queue of QUEUE_DEPTH entries absorbs output stalls; input stalls when it is full
// arst_n clears the parser to expect a delay byte, no running status, queue and output empty
module midi_event_stream_parser import mesp_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  stream_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_kind,
	output logic [3:0]  channel,
	output logic [6:0]  first_data,
	output logic [6:0]  second_data,
	output logic [13:0] wide_value
);

`include "midi_event_stream_parser_macros.svh"

	logic   push, pop, q_valid, q_full;
	entry_t push_entry, q_entry;

	assign in_stall = q_full;

	mesp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.q_full     (q_full),
		.stream_byte(stream_byte),
		.push       (push),
		.push_entry (push_entry)
	);

	mesp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_full    (q_full),
		.q_entry   (q_entry)
	);

	mesp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_entry    (q_entry),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_kind (event_kind),
		.channel    (channel),
		.first_data (first_data),
		.second_data(second_data),
		.wide_value (wide_value)
	);

	`MESP_ASSERT_IMPL(a_note_on_velocity, out_valid && event_kind == KIND_NOTE_ON,
		second_data != 7'd0, "note on with zero velocity")
	`MESP_ASSERT_IMPL(a_delay_fields, out_valid && event_kind == KIND_DELAY,
		channel == 4'd0 && first_data == 7'd0 && second_data == 7'd0, "delay fields set")
	`MESP_ASSERT_IMPL(a_wide_unused, out_valid && event_kind != KIND_DELAY &&
		event_kind != KIND_BEND, wide_value == 14'd0, "wide value on plain event")
	`MESP_ASSERT_NEXT(a_drain, out_valid && !out_stall && !q_valid, !out_valid,
		"output valid without a queued transaction")

endmodule

>>> sim/midi_event_stream_parser_tb.sv
module midi_event_stream_parser_tb import mesp_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_BYTES = 550;
	localparam int MAX_REPORTS = 10;

	// high nibble of a status byte
	localparam logic [3:0] GRP_NOTE_OFF   = 4'h8;
	localparam logic [3:0] GRP_NOTE_ON    = 4'h9;
	localparam logic [3:0] GRP_KEY_PRESS  = 4'hA;
	localparam logic [3:0] GRP_CTRL       = 4'hB;
	localparam logic [3:0] GRP_PROGRAM    = 4'hC;
	localparam logic [3:0] GRP_CHAN_PRESS = 4'hD;
	localparam logic [3:0] GRP_BEND       = 4'hE;
	localparam logic [3:0] GRP_SYSTEM     = 4'hF;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  chan;
		logic [6:0]  d1;
		logic [6:0]  d2;
		logic [13:0] wide;
	} midi_msg_t;

	localparam midi_msg_t NO_MSG = '0;

	typedef struct packed {
		logic [7:0] b;
		logic       fixed;
		midi_msg_t  msg;
	} script_row_t;

	localparam int SCRIPT_LEN = 37;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  stream_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  event_kind;
	logic [3:0]  channel;
	logic [6:0]  first_data;
	logic [6:0]  second_data;
	logic [13:0] wide_value;

	// parser state as the stream should leave it
	phase_t     parse_st = PH_DELAY_FIRST;
	logic [7:0] last_status = 8'h00;
	logic [6:0] held_byte = 7'd0;
	logic [6:0] delay_top = 7'd0;

	midi_msg_t pending_msgs[$];
	int        mismatches = 0;
	int        bytes_sent = 0;
	int        msgs_seen = 0;
	int        kind_seen[8];
	bit        src_quiet = 1'b0;
	bit        sink_quiet = 1'b0;

	script_row_t script [SCRIPT_LEN] = '{
		'{8'h00, 1'b1, '{KIND_DELAY, 4'd0, 7'd0, 7'd0, 14'd0}},
		// data with no status yet: consumed silently
		'{8'h11, 1'b0, NO_MSG},
		'{8'h22, 1'b0, NO_MSG},
		'{8'hFF, 1'b0, NO_MSG},
		'{8'hFF, 1'b1, '{KIND_DELAY, 4'd0, 7'd0, 7'd0, 14'h3FFF}},
		'{8'h9F, 1'b0, NO_MSG},
		'{8'hFF, 1'b0, NO_MSG},
		'{8'hFF, 1'b1, '{KIND_NOTE_ON, 4'hF, 7'h7F, 7'h7F, 14'd0}},
		'{8'h7F, 1'b1, '{KIND_DELAY, 4'd0, 7'd0, 7'd0, 14'd127}},
		// running status note on with zero velocity
		'{8'h3C, 1'b0, NO_MSG},
		'{8'h00, 1'b1, '{KIND_NOTE_OFF, 4'hF, 7'h3C, 7'd0, 14'd0}},
		'{8'h01, 1'b0, NO_MSG},
		'{8'h83, 1'b0, NO_MSG},
		'{8'h40, 1'b0, NO_MSG},
		'{8'h40, 1'b0, NO_MSG},
		'{8'h05, 1'b0, NO_MSG},
		'{8'hC0, 1'b0, NO_MSG},
		'{8'h85, 1'b0, NO_MSG},
		'{8'h06, 1'b0, NO_MSG},
		'{8'hD7, 1'b0, NO_MSG},
		'{8'h22, 1'b0, NO_MSG},
		'{8'h07, 1'b0, NO_MSG},
		'{8'hE1, 1'b0, NO_MSG},
		'{8'h7F, 1'b0, NO_MSG},
		'{8'h7F, 1'b1, '{KIND_BEND, 4'h1, 7'd0, 7'd0, 14'h3FFF}},
		'{8'h08, 1'b0, NO_MSG},
		'{8'hA2, 1'b0, NO_MSG},
		'{8'h10, 1'b0, NO_MSG},
		'{8'h20, 1'b0, NO_MSG},
		'{8'h09, 1'b0, NO_MSG},
		'{8'hB5, 1'b0, NO_MSG},
		'{8'h07, 1'b0, NO_MSG},
		'{8'h64, 1'b0, NO_MSG},
		'{8'h0A, 1'b0, NO_MSG},
		// system status eats two data bytes
		'{8'hF0, 1'b0, NO_MSG},
		'{8'h12, 1'b0, NO_MSG},
		'{8'h34, 1'b0, NO_MSG}
	};

	midi_event_stream_parser u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.stream_byte(stream_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_kind (event_kind),
		.channel    (channel),
		.first_data (first_data),
		.second_data(second_data),
		.wide_value (wide_value)
	);

	always #6 clk = ~clk;

	function automatic bit close_event(input logic [6:0] d1, input logic [6:0] d2,
			output midi_msg_t msg);
		msg = '0;
		msg.chan = last_status[3:0];
		parse_st = PH_DELAY_FIRST;
		close_event = 1'b1;
		case (last_status[7:4])
			GRP_NOTE_OFF: begin
				msg.kind = KIND_NOTE_OFF;
				msg.d1 = d1;
				msg.d2 = d2;
			end
			GRP_NOTE_ON: begin
				msg.kind = (d2 == 7'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
				msg.d1 = d1;
				msg.d2 = d2;
			end
			GRP_KEY_PRESS: begin
				msg.kind = KIND_KEY_PRESS;
				msg.d1 = d1;
				msg.d2 = d2;
			end
			GRP_CTRL: begin
				msg.kind = KIND_CTRL;
				msg.d1 = d1;
				msg.d2 = d2;
			end
			GRP_PROGRAM: begin
				msg.kind = KIND_PROGRAM;
				msg.d1 = d1;
			end
			GRP_CHAN_PRESS: begin
				msg.kind = KIND_CHAN_PRESS;
				msg.d2 = d1;
			end
			GRP_BEND: begin
				msg.kind = KIND_BEND;
				msg.wide = {d2, d1};
			end
			default: close_event = 1'b0;
		endcase
	endfunction

	function automatic bit take_data_one(input logic [6:0] d1, output midi_msg_t msg);
		if (last_status[7:5] == ONE_DATA_TOP)
			return close_event(d1, 7'd0, msg);
		msg = '0;
		held_byte = d1;
		parse_st = PH_DATA_TWO;
		return 1'b0;
	endfunction

	// advances the expected parser state by one byte, returns 1 when a message completes
	function automatic bit decode_byte(input logic [7:0] b, output midi_msg_t msg);
		msg = '0;
		case (parse_st)
			PH_DELAY_FIRST: begin
				if (b[7]) begin
					delay_top = b[6:0];
					parse_st = PH_DELAY_SECOND;
					return 1'b0;
				end
				msg.kind = KIND_DELAY;
				msg.wide = {7'd0, b[6:0]};
				parse_st = PH_EVENT_START;
				return 1'b1;
			end
			PH_DELAY_SECOND: begin
				msg.kind = KIND_DELAY;
				msg.wide = {delay_top, 7'd0} | {6'd0, b};
				parse_st = PH_EVENT_START;
				return 1'b1;
			end
			PH_EVENT_START: begin
				if (b[7]) begin
					last_status = b;
					parse_st = PH_DATA_ONE;
					return 1'b0;
				end
				return take_data_one(b[6:0], msg);
			end
			PH_DATA_ONE: return take_data_one(b[6:0], msg);
			PH_DATA_TWO: return close_event(held_byte, b[6:0], msg);
			default: begin
				parse_st = PH_DELAY_FIRST;
				return 1'b0;
			end
		endcase
	endfunction

	function automatic logic [7:0] pick_data(input bit top_ok);
		logic [7:0] v;
		case ($urandom_range(0, 5))
			0: v = 8'h00;
			1: v = 8'h7F;
			default: v = {1'b0, 7'($urandom)};
		endcase
		if (top_ok && $urandom_range(0, 3) == 0)
			v[7] = 1'b1;
		return v;
	endfunction

	function automatic logic [7:0] pick_status();
		if ($urandom_range(0, 9) == 0)
			return {GRP_SYSTEM, 4'($urandom)};
		return {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
	endfunction

	task automatic push_byte(input logic [7:0] b, input bit has_fixed,
			input midi_msg_t fixed_msg);
		int        gap;
		midi_msg_t pred;
		bit        got;
		if (bytes_sent % 32 == 0)
			src_quiet = ($urandom_range(0, 2) == 0);
		gap = src_quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		stream_byte <= b;
		do @(posedge clk); while (in_stall !== 1'b0);
		bytes_sent++;
		got = decode_byte(b, pred);
		if (got)
			pending_msgs.push_back(has_fixed ? fixed_msg : pred);
	endtask

	// one delay token and one event, sometimes noise or a cut-short event
	task automatic send_group();
		int         sel;
		logic [7:0] st;
		bit         top_ok;
		while (parse_st != PH_DELAY_FIRST)
			push_byte(8'($urandom), 1'b0, NO_MSG);
		if ($urandom_range(0, 3) == 0) begin
			push_byte({1'b1, 7'($urandom)}, 1'b0, NO_MSG);
			push_byte(8'($urandom), 1'b0, NO_MSG);
		end else begin
			push_byte({1'b0, 7'($urandom)}, 1'b0, NO_MSG);
		end
		sel = $urandom_range(0, 19);
		if (sel == 0) begin
			repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0, NO_MSG);
			return;
		end
		if (sel < 12 || last_status == 8'h00) begin
			st = pick_status();
			push_byte(st, 1'b0, NO_MSG);
			top_ok = 1'b1;
		end else begin
			st = last_status;
			top_ok = 1'b0;
		end
		push_byte(pick_data(top_ok), 1'b0, NO_MSG);
		if (st[7:5] != ONE_DATA_TOP && sel != 1)
			push_byte(pick_data(1'b1), 1'b0, NO_MSG);
	endtask

	initial begin : result_sink
		int        hold;
		midi_msg_t want;
		wait (arst_n === 1'b1);
		forever begin
			if (msgs_seen % 32 == 0)
				sink_quiet = ($urandom_range(0, 2) == 0);
			hold = sink_quiet ? 0 : $urandom_range(0, 9);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (out_valid !== 1'b1);
			msgs_seen++;
			if (pending_msgs.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: kind %0d ch %0d d1 %0h d2 %0h wide %0h",
						event_kind, channel, first_data, second_data, wide_value);
			end else begin
				want = pending_msgs.pop_front();
				kind_seen[want.kind]++;
				if (event_kind !== want.kind || channel !== want.chan ||
						first_data !== want.d1 || second_data !== want.d2 ||
						wide_value !== want.wide) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("mismatch: expected kind %0d ch %0d d1 %0h d2 %0h wide %0h, %s",
							want.kind, want.chan, want.d1, want.d2, want.wide,
							$sformatf("got kind %0d ch %0d d1 %0h d2 %0h wide %0h",
								event_kind, channel, first_data, second_data,
								wide_value));
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("timeout waiting for the parser");
		$display("Some tests failed");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (script[i])
			push_byte(script[i].b, script[i].fixed, script[i].msg);
		while (bytes_sent < SCRIPT_LEN + RANDOM_BYTES)
			send_group();
		in_valid <= 1'b0;
		while (pending_msgs.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (pending_msgs.size() != 0) begin
			mismatches += pending_msgs.size();
			$display("%0d expected results never arrived", pending_msgs.size());
		end
		$display("drove %0d stream bytes and checked %0d results, %0d mismatches",
			bytes_sent, msgs_seen, mismatches);
		$display("by kind: off %0d on %0d key %0d ctrl %0d prog %0d chan %0d bend %0d delay %0d",
			kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
			kind_seen[4], kind_seen[5], kind_seen[6], kind_seen[7]);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
